// ----- rtl/byte_fifo_command_detector_top_assert.svh -----
// Assertion macros for the byte FIFO command detector.
`ifndef BYTE_FIFO_COMMAND_DETECTOR_TOP_ASSERT_SVH
`define BYTE_FIFO_COMMAND_DETECTOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define BFCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BFCD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define BFCD_ASSERT(lbl, prop, msg)
`define BFCD_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/bfcd_pkg.sv -----
package bfcd_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;
  localparam logic [1:0] OP_DETECT = 2'd3;

  localparam logic [1:0] FOUND_NONE = 2'd0;
  localparam logic [1:0] FOUND_LD   = 2'd1;
  localparam logic [1:0] FOUND_BTN  = 2'd2;

  localparam int LD_LEN  = 3;
  localparam int BTN_LEN = 5;

  localparam logic [7:0] CMD_LD [LD_LEN] = '{8'h4C, 8'h44, 8'h31};
  localparam logic [7:0] CMD_BTN [BTN_LEN] = '{8'h42, 8'h55, 8'h54, 8'h4E, 8'h31};

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  function automatic ptr_t ptr_add(input ptr_t p, input cnt_t d);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - PTR_W){1'b0}}, p} + {1'b0, d};
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// ----- rtl/bfcd_ram.sv -----
module bfcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/byte_fifo_command_detector_top.sv -----
// Channel   Handshake            Beat
// ------    ---------            ----
// command   start, busy          opcode, write_byte, peek_offset
// result    done (one cycle)     ok, byte_out, command_found, dropped, fill_level
//
// Write and every refused operation: result one cycle after the start beat.
// Read and peek: the byte comes from the registered read of the byte RAM in S_RDATA.
// Detect: each byte examined at a head position (up to five per position) goes
// through S_DSCAN and S_DCMP; a position too short for a command drops in S_DSCAN.
// Synchronous reset empties the FIFO; the RAM keeps its contents.
// The receiver cannot stall: each result beat shows for one cycle only.
`include "byte_fifo_command_detector_top_assert.svh"

module byte_fifo_command_detector_top
  import bfcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode,
  input  logic [7:0] write_byte,
  input  logic [5:0] peek_offset,
  output logic       done,
  output logic       ok,
  output logic [7:0] byte_out,
  output logic [1:0] command_found,
  output logic [6:0] dropped,
  output logic [6:0] fill_level
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RDATA = 2'd1;
  localparam logic [1:0] S_DSCAN = 2'd2;
  localparam logic [1:0] S_DCMP  = 2'd3;

  logic [1:0] state;
  ptr_t       head;
  ptr_t       tail;
  cnt_t       count;
  logic       is_read;
  logic [2:0] k;
  logic       ld_ok;
  logic       btn_ok;

  logic       mem_we;
  ptr_t       mem_raddr;
  logic [7:0] mem_rdata;

  logic       ld_hit;
  logic       btn_hit;
  cnt_t       count_dec;

  assign busy       = (state != S_IDLE);
  assign fill_level = 7'(count);
  assign mem_we     = (state == S_IDLE) && start && (opcode == OP_WRITE) &&
                      (count < CNT_W'(DEPTH));
  assign count_dec  = count - CNT_W'(1);

  always_comb begin
    if (state == S_IDLE) begin
      mem_raddr = ptr_add(head, (opcode == OP_PEEK) ? CNT_W'(peek_offset) : CNT_W'(0));
    end else begin
      mem_raddr = ptr_add(head, CNT_W'(k));
    end
  end

  bfcd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail),
    .wdata (write_byte),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign ld_hit  = ld_ok && (k < 3'(LD_LEN)) && (mem_rdata == CMD_LD[k[1:0]]);
  assign btn_hit = btn_ok && (mem_rdata == CMD_BTN[k]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            is_read       <= (opcode == OP_READ);
            ok            <= 1'b0;
            byte_out      <= 8'd0;
            command_found <= FOUND_NONE;
            dropped       <= 7'd0;
            k             <= 3'd0;
            ld_ok         <= (count >= CNT_W'(LD_LEN));
            btn_ok        <= (count >= CNT_W'(BTN_LEN));
            unique case (opcode)
              OP_WRITE: begin
                done <= 1'b1;
                if (count < CNT_W'(DEPTH)) begin
                  tail  <= ptr_add(tail, CNT_W'(1));
                  count <= count + CNT_W'(1);
                  ok    <= 1'b1;
                end
              end
              OP_READ: begin
                if (count != '0) begin
                  state <= S_RDATA;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_PEEK: begin
                if ({1'b0, peek_offset} < 7'(count)) begin
                  state <= S_RDATA;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_DETECT: begin
                if (count != '0) begin
                  state <= S_DSCAN;
                end else begin
                  done <= 1'b1;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_RDATA: begin
          ok       <= 1'b1;
          byte_out <= mem_rdata;
          done     <= 1'b1;
          state    <= S_IDLE;
          if (is_read) begin
            head  <= ptr_add(head, CNT_W'(1));
            count <= count_dec;
          end
        end
        S_DSCAN: begin
          if (!ld_ok && !btn_ok) begin
            // drop the head byte as corrupt
            head    <= ptr_add(head, CNT_W'(1));
            count   <= count_dec;
            dropped <= dropped + 7'd1;
            k       <= 3'd0;
            ld_ok   <= (count_dec >= CNT_W'(LD_LEN));
            btn_ok  <= (count_dec >= CNT_W'(BTN_LEN));
            if (count == CNT_W'(1)) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            state <= S_DCMP;
          end
        end
        S_DCMP: begin
          priority if (ld_hit && (k == 3'(LD_LEN - 1))) begin
            head          <= ptr_add(head, CNT_W'(LD_LEN));
            count         <= count - CNT_W'(LD_LEN);
            command_found <= FOUND_LD;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else if (btn_hit && (k == 3'(BTN_LEN - 1))) begin
            head          <= ptr_add(head, CNT_W'(BTN_LEN));
            count         <= count - CNT_W'(BTN_LEN);
            command_found <= FOUND_BTN;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else if (!ld_hit && !btn_hit) begin
            head    <= ptr_add(head, CNT_W'(1));
            count   <= count_dec;
            dropped <= dropped + 7'd1;
            k       <= 3'd0;
            ld_ok   <= (count_dec >= CNT_W'(LD_LEN));
            btn_ok  <= (count_dec >= CNT_W'(BTN_LEN));
            if (count == CNT_W'(1)) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_DSCAN;
            end
          end else begin
            // advance to the next byte of the candidate command
            k      <= k + 3'd1;
            ld_ok  <= ld_hit;
            btn_ok <= btn_hit;
            state  <= S_DSCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BFCD_ASSERT(a_count_range, count <= CNT_W'(DEPTH), "fill count exceeds depth")
  `BFCD_ASSERT(a_ptr_consistent, tail == ptr_add(head, count), "head, tail and count disagree")
  `BFCD_ASSERT_IMPL(a_scan_nonempty, (state == S_DSCAN) || (state == S_DCMP), count != '0, "detect scan on empty FIFO")
  `BFCD_ASSERT_IMPL(a_done_exclusive, done, !(ok && (command_found != FOUND_NONE)), "ok and command both reported")
  `BFCD_ASSERT_IMPL(a_done_cause, done, $past(state != S_IDLE) || $past(start), "result without a command")

endmodule

// ----- tb/tb_byte_fifo_command_detector_top.sv -----
module tb_byte_fifo_command_detector_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bfcd_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_ITEMS  = 260;
  localparam int SETTLE_CYCLES = 50;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic       ok;
    logic [7:0] byte_out;
    logic [1:0] found;
    logic [6:0] dropped;
    logic [6:0] fill;
  } fifo_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] opcode = OP_WRITE;
  logic [7:0] write_byte = 8'h00;
  logic [5:0] peek_offset = 6'd0;
  logic       done;
  logic       ok;
  logic [7:0] byte_out;
  logic [1:0] command_found;
  logic [6:0] dropped;
  logic [6:0] fill_level;

  byte_fifo_command_detector_top uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .write_byte    (write_byte),
    .peek_offset   (peek_offset),
    .done          (done),
    .ok            (ok),
    .byte_out      (byte_out),
    .command_found (command_found),
    .dropped       (dropped),
    .fill_level    (fill_level)
  );

  always #5 clk = ~clk;

  logic [7:0]  shadow_mem [DEPTH];
  int unsigned shadow_head = 0;
  int unsigned shadow_tail = 0;
  int unsigned shadow_count = 0;

  fifo_result_t expected_fifo_results[$];

  int beats_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int ld_hits = 0;
  int btn_hits = 0;
  int refusals = 0;
  int burst_left = 0;
  int cycle_count = 0;

  function automatic void drop_shadow_head();
    shadow_head = (shadow_head + 1) % DEPTH;
    shadow_count--;
  endfunction

  function automatic bit head_holds_command(input bit btn);
    int  len;
    bit  hit;
    len = btn ? BTN_LEN : LD_LEN;
    hit = (shadow_count >= len);
    for (int i = 0; i < len && hit; i++) begin
      if (btn) begin
        hit = (shadow_mem[(shadow_head + i) % DEPTH] == CMD_BTN[i]);
      end else begin
        hit = (shadow_mem[(shadow_head + i) % DEPTH] == CMD_LD[i]);
      end
    end
    return hit;
  endfunction

  function automatic fifo_result_t predict_fifo_op(input logic [1:0] op,
                                                   input logic [7:0] wb,
                                                   input logic [5:0] off);
    fifo_result_t r;
    bit           hunting;
    r = '0;
    case (op)
      OP_WRITE: begin
        if (shadow_count < DEPTH) begin
          shadow_mem[shadow_tail] = wb;
          shadow_tail = (shadow_tail + 1) % DEPTH;
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (shadow_count != 0) begin
          r.byte_out = shadow_mem[shadow_head];
          drop_shadow_head();
          r.ok = 1'b1;
        end
      end
      OP_PEEK: begin
        if (off < shadow_count) begin
          r.byte_out = shadow_mem[(shadow_head + off) % DEPTH];
          r.ok = 1'b1;
        end
      end
      default: begin
        hunting = 1'b1;
        while (hunting && shadow_count != 0) begin
          if (head_holds_command(1'b0)) begin
            repeat (LD_LEN) drop_shadow_head();
            r.found = FOUND_LD;
            hunting = 1'b0;
          end else if (head_holds_command(1'b1)) begin
            repeat (BTN_LEN) drop_shadow_head();
            r.found = FOUND_BTN;
            hunting = 1'b0;
          end else begin
            drop_shadow_head();
            r.dropped = r.dropped + 7'd1;
          end
        end
      end
    endcase
    r.fill = 7'(shadow_count);
    if (op != OP_DETECT && !r.ok) refusals++;
    if (r.found == FOUND_LD) ld_hits++;
    if (r.found == FOUND_BTN) btn_hits++;
    return r;
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [7:0] wb, input logic [5:0] off);
    int gap;
    if (burst_left == 0) begin
      start       <= 1'b0;
      opcode      <= 2'($urandom);
      write_byte  <= 8'($urandom);
      peek_offset <= 6'($urandom);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    start       <= 1'b1;
    opcode      <= op;
    write_byte  <= wb;
    peek_offset <= off;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_fifo_results.push_back(predict_fifo_op(op, wb, off));
    beats_sent++;
  endtask

  task automatic send_write(input logic [7:0] wb);
    send_beat(OP_WRITE, wb, 6'($urandom));
  endtask

  task automatic send_command_bytes(input bit btn, input int keep);
    for (int i = 0; i < keep; i++) begin
      if (btn) begin
        send_write(CMD_BTN[i]);
      end else begin
        send_write(CMD_LD[i]);
      end
    end
  endtask

  task automatic send_peek();
    logic [5:0] off;
    if (shadow_count == 0 || $urandom_range(0, 3) == 0) begin
      off = 6'($urandom);
    end else begin
      off = 6'($urandom_range(0, shadow_count - 1));
    end
    send_beat(OP_PEEK, 8'($urandom), off);
  endtask

  always @(posedge clk) begin
    fifo_result_t seen;
    fifo_result_t want;
    if (!rst && done) begin
      seen = '{ok, byte_out, command_found, dropped, fill_level};
      if (expected_fifo_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("[%0t] unexpected result beat: ok=%0d byte=%02h found=%0d dropped=%0d fill=%0d",
                   $realtime, seen.ok, seen.byte_out, seen.found, seen.dropped, seen.fill);
        end
      end else begin
        want = expected_fifo_results.pop_front();
        results_checked++;
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] result %0d mismatch", $realtime, results_checked);
            $display("  expected ok=%0d byte=%02h found=%0d dropped=%0d fill=%0d",
                     want.ok, want.byte_out, want.found, want.dropped, want.fill);
            $display("  actual   ok=%0d byte=%02h found=%0d dropped=%0d fill=%0d",
                     seen.ok, seen.byte_out, seen.found, seen.dropped, seen.fill);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_fifo_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic apply_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  endtask

  task automatic test_empty_refusals();
    send_beat(OP_READ, 8'hFF, 6'd0);
    send_beat(OP_PEEK, 8'h00, 6'd0);
    send_beat(OP_PEEK, 8'h00, 6'd63);
    send_beat(OP_DETECT, 8'hFF, 6'd63);
  endtask

  task automatic test_command_detect();
    send_command_bytes(1'b0, LD_LEN);
    send_beat(OP_DETECT, 8'h00, 6'd0);
    send_write(8'hFF);
    send_write(8'h00);
    send_command_bytes(1'b1, BTN_LEN);
    send_beat(OP_DETECT, 8'h00, 6'd0);
    // partial command at the head: both bytes drop as corrupt
    send_command_bytes(1'b0, LD_LEN - 1);
    send_beat(OP_DETECT, 8'h00, 6'd0);
  endtask

  task automatic test_read_peek();
    send_write(8'hA5);
    send_write(8'h5A);
    send_beat(OP_PEEK, 8'h00, 6'd1);
    send_beat(OP_PEEK, 8'h00, 6'd2);
    send_beat(OP_READ, 8'h00, 6'd0);
    send_beat(OP_READ, 8'h00, 6'd0);
    send_beat(OP_READ, 8'h00, 6'd0);
  endtask

  task automatic test_full_buffer();
    repeat (2) begin
      while (shadow_count < DEPTH) begin
        if ($urandom_range(0, 5) == 0) begin
          send_command_bytes(1'($urandom), $urandom_range(0, 1) ? BTN_LEN : LD_LEN);
        end else begin
          send_write(8'($urandom));
        end
      end
      send_write(8'($urandom));
      send_write(8'($urandom));
      send_beat(OP_PEEK, 8'h00, 6'd63);
      send_beat(OP_PEEK, 8'h00, 6'd0);
      send_beat(OP_DETECT, 8'($urandom), 6'($urandom));
      repeat ($urandom_range(3, 9)) send_write(8'($urandom));
      repeat ($urandom_range(1, 4)) send_beat(OP_READ, 8'($urandom), 6'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int target;
    int pick;
    int len;
    bit btn;
    target = beats_sent + RANDOM_ITEMS;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        repeat ($urandom_range(0, 3)) send_write(8'($urandom));
        btn = 1'($urandom);
        len = btn ? BTN_LEN : LD_LEN;
        if ($urandom_range(0, 5) == 0) len = $urandom_range(1, len - 1);
        send_command_bytes(btn, len);
        if ($urandom_range(0, 4) < 3) send_beat(OP_DETECT, 8'($urandom), 6'($urandom));
      end else if (pick < 60) begin
        send_write(8'($urandom));
      end else if (pick < 70) begin
        send_beat(OP_READ, 8'($urandom), 6'($urandom));
      end else if (pick < 85) begin
        send_peek();
      end else begin
        send_beat(OP_DETECT, 8'($urandom), 6'($urandom));
      end
    end
  endtask

  initial begin
    apply_reset();
    test_empty_refusals();
    test_command_detect();
    test_read_peek();
    test_full_buffer();
    test_random_traffic();
    start <= 1'b0;
    while (expected_fifo_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d operations, checked %0d results, %0d mismatches",
             beats_sent, results_checked, mismatch_count);
    $display("detects matched LD1 %0d and BUTN1 %0d times; %0d refused operations",
             ld_hits, btn_hits, refusals);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
